// ===== rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants
// Register indexes, reset values and fixed field widths of the stereo delay.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int GAIN_W = 16;
  localparam int LEN_W  = 16;
  localparam int IDX_W  = 2;

  typedef logic [GAIN_W-1:0] gain_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic [IDX_W-1:0] {
    REG_LEFT_LENGTH   = 2'd0,
    REG_RIGHT_LENGTH  = 2'd1,
    REG_FEEDBACK_GAIN = 2'd2,
    REG_WET_GAIN      = 2'd3
  } reg_idx_t;

  localparam len_t  LEFT_LENGTH_RST   = 16'd2400;
  localparam len_t  RIGHT_LENGTH_RST  = 16'd2880;
  localparam gain_t FEEDBACK_GAIN_RST = 16'd12288;
  localparam gain_t WET_GAIN_RST      = 16'd32768;

  // output queue depth, covers one item in the mixing stage plus a stall
  localparam int QDEPTH = 3;
  localparam int QPTR_W = 2;

endpackage

// ===== rtl/sfd_ram.sv =====
// ----------------------------------------------------------------------------
// sfd_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sfd_lane.sv =====
// ----------------------------------------------------------------------------
// sfd_lane: one channel of the feedback delay
// Circular delay line in RAM, position counter, wet and feedback mixing.
// ----------------------------------------------------------------------------
module sfd_lane #(
  parameter int MAX_DELAY    = 32768,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sfd_pkg::len_t                  length,
  input  sfd_pkg::gain_t                 fb_gain,
  input  sfd_pkg::gain_t                 wet_gain,
  input  logic                           accept,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           res_valid,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic                           clr_busy
);

  import sfd_pkg::*;

  localparam int AW   = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int CW   = (AW + 1 > LEN_W + 1) ? AW + 1 : LEN_W + 1;
  localparam int ACCW = SAMPLE_WIDTH + 18;
  localparam int RW   = SAMPLE_WIDTH + 3;

  logic [AW-1:0]                  pos;
  logic [AW-1:0]                  pos_next;
  logic [CW-1:0]                  eff_len;
  logic [CW-1:0]                  pos_inc;
  logic                           s1_valid;
  logic [AW-1:0]                  s1_addr;
  logic signed [SAMPLE_WIDTH-1:0] s1_in;
  logic                           fwd;
  logic signed [SAMPLE_WIDTH-1:0] fwd_data;
  logic [AW-1:0]                  clr_addr;
  logic signed [SAMPLE_WIDTH-1:0] rd_data;
  logic signed [SAMPLE_WIDTH-1:0] old;
  logic signed [SAMPLE_WIDTH-1:0] store;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [SAMPLE_WIDTH-1:0]        ram_wdata;

  // in + gain*old, rounded, floor shift by 15, saturated
  function automatic logic signed [SAMPLE_WIDTH-1:0] mix_sat(
    input logic signed [SAMPLE_WIDTH-1:0] din,
    input gain_t                          gain,
    input logic signed [SAMPLE_WIDTH-1:0] prev
  );
    logic signed [SAMPLE_WIDTH+16:0] prod;
    logic signed [ACCW-1:0]          acc;
    logic signed [RW-1:0]            r;
    logic signed [SAMPLE_WIDTH-1:0]  res;
    prod = $signed({1'b0, gain}) * prev;
    acc  = (ACCW'(din) <<< 15) + ACCW'(prod) + ACCW'(16384);
    r    = RW'(acc >>> 15);
    if (r[RW-1:SAMPLE_WIDTH-1] == '0 || r[RW-1:SAMPLE_WIDTH-1] == '1) begin
      res = r[SAMPLE_WIDTH-1:0];
    end else if (r[RW-1]) begin
      res = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

  // zero acts as one, above capacity acts as capacity
  always_comb begin
    eff_len = CW'(length);
    if (eff_len == '0) begin
      eff_len = CW'(1);
    end else if (eff_len > CW'(MAX_DELAY)) begin
      eff_len = CW'(MAX_DELAY);
    end
    pos_inc  = CW'(pos) + CW'(1);
    pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[AW-1:0];
  end

  // the slot read this cycle may be the one being written right now
  assign old        = fwd ? fwd_data : rd_data;
  assign store      = mix_sat(s1_in, fb_gain, old);
  assign sample_out = mix_sat(s1_in, wet_gain, old);
  assign res_valid  = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        pos <= pos_next;
        fwd <= s1_valid && (s1_addr == pos);
      end
      if (clr_busy) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(MAX_DELAY - 1)) begin
          clr_busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr  <= pos;
      s1_in    <= sample_in;
      fwd_data <= store;
    end
  end

  assign ram_we    = clr_busy | s1_valid;
  assign ram_waddr = clr_busy ? clr_addr : s1_addr;
  assign ram_wdata = clr_busy ? '0 : store;

  sfd_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_DELAY),
    .AW    (AW)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (pos),
    .rdata (rd_data)
  );

endmodule

// ===== rtl/sfd_outq.sv =====
// ----------------------------------------------------------------------------
// sfd_outq: result queue
// Small register queue between the mixing stage and the master side.
// ----------------------------------------------------------------------------
module sfd_outq #(
  parameter int WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [WIDTH-1:0]          din,
  input  logic                      pop,
  output logic                      valid,
  output logic [WIDTH-1:0]          dout,
  output logic [sfd_pkg::QPTR_W-1:0] count
);

  import sfd_pkg::*;

  logic [WIDTH-1:0]  mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign valid  = (count != '0);
  assign dout   = mem[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !do_pop) begin
        count <= count + QPTR_W'(1);
      end else if (!push && do_pop) begin
        count <= count - QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== rtl/stereo_feedback_delay.sv =====
// ----------------------------------------------------------------------------
// stereo_feedback_delay: two-channel feedback comb delay
// Left and right lanes each own a circular delay line; results are merged
// into one stereo frame per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one stereo frame per request: left_in in tdata[15:0],
//   right_in in tdata[31:16]. m_axis returns one frame per request in the
//   same layout: left_out, right_out.
//   Configuration goes through cfg_wr_en / cfg_index / cfg_data, index 0..3
//   = left_length, right_length, feedback_gain, wet_gain. Write only while
//   no request is in flight.
//   Throughput: one frame per cycle while s_axis_tready is high. Each lane
//   does one read and one write of its delay RAM per frame; the write of
//   one frame and the read of the next share a cycle, with a bypass when
//   both hit the same slot. Pipeline: an accepted frame is captured in the
//   lane stage registers, mixed combinationally from them, pushed into the
//   result queue and offered on m_axis from there.
//   Reset: registers take their defaults, positions go to zero, then a
//   clearing pass writes zero to every delay slot (MAX_DELAY slots,
//   32768 by default) with s_axis_tready low.
//   Stall: a three-entry result queue absorbs m_axis_tready low; s_axis
//   drops ready once the queue and the mixing stage hold three results
//   between them.
// ----------------------------------------------------------------------------
module stereo_feedback_delay #(
  parameter int MAX_DELAY    = 32768,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // left_in, right_in
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // left_out, right_out
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  input  logic                                    cfg_wr_en,
  input  logic [sfd_pkg::IDX_W-1:0]               cfg_index,
  input  logic [sfd_pkg::LEN_W-1:0]               cfg_data
);

  import sfd_pkg::*;

  localparam int TW = ((2*SAMPLE_WIDTH+7)/8)*8;
  localparam int PW = 2*SAMPLE_WIDTH;

  len_t  left_length;
  len_t  right_length;
  gain_t feedback_gain;
  gain_t wet_gain;

  logic                           s_accept;
  logic                           left_valid;
  logic                           right_valid;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;
  logic                           left_busy;
  logic                           right_busy;
  logic                           clr_busy;
  logic [QPTR_W-1:0]              q_count;
  logic [QPTR_W:0]                in_flight;
  logic [PW-1:0]                  q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_length   <= LEFT_LENGTH_RST;
      right_length  <= RIGHT_LENGTH_RST;
      feedback_gain <= FEEDBACK_GAIN_RST;
      wet_gain      <= WET_GAIN_RST;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_LEFT_LENGTH:   left_length   <= cfg_data;
        REG_RIGHT_LENGTH:  right_length  <= cfg_data;
        REG_FEEDBACK_GAIN: feedback_gain <= cfg_data;
        REG_WET_GAIN:      wet_gain      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign clr_busy      = left_busy | right_busy;
  assign in_flight     = {1'b0, q_count} + (QPTR_W+1)'(left_valid);
  assign s_axis_tready = !clr_busy && (in_flight < (QPTR_W+1)'(QDEPTH));
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  sfd_lane #(
    .MAX_DELAY    (MAX_DELAY),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_left (
    .clk        (clk),
    .rst        (rst),
    .length     (left_length),
    .fb_gain    (feedback_gain),
    .wet_gain   (wet_gain),
    .accept     (s_accept),
    .sample_in  ($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
    .res_valid  (left_valid),
    .sample_out (left_out),
    .clr_busy   (left_busy)
  );

  sfd_lane #(
    .MAX_DELAY    (MAX_DELAY),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_right (
    .clk        (clk),
    .rst        (rst),
    .length     (right_length),
    .fb_gain    (feedback_gain),
    .wet_gain   (wet_gain),
    .accept     (s_accept),
    .sample_in  ($signed(s_axis_tdata[PW-1:SAMPLE_WIDTH])),
    .res_valid  (right_valid),
    .sample_out (right_out),
    .clr_busy   (right_busy)
  );

  // merge the two lanes into one frame
  sfd_outq #(
    .WIDTH (PW)
  ) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (left_valid),
    .din   ({right_out, left_out}),
    .pop   (m_axis_tready),
    .valid (m_axis_tvalid),
    .dout  (q_dout),
    .count (q_count)
  );

  assign m_axis_tdata = TW'(q_dout);

`ifndef SYNTHESIS
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    left_valid == right_valid)
    else $error("lane result valids differ");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    s_accept |-> !left_busy && !right_busy)
    else $error("request accepted during clearing pass");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(left_valid && q_count == QPTR_W'(QDEPTH) && !m_axis_tready))
    else $error("result queue overflow");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> left_valid)
    else $error("accepted request produced no result");

  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !s_axis_tready)
    else $error("ready right after reset");
`endif

endmodule

// ===== dv/stereo_feedback_delay_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_delay_test: self-checking bench for the stereo comb delay
// Streams stereo frames through the block and mirrors both delay lanes in
// a local predictor. Directed frames hit sample extremes, saturation, zero
// and oversized lengths and a length shrunk mid-stream. Random segments then
// run with random register settings and back-pressure on either side.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_test;
  import sfd_pkg::*;

  localparam int DEPTH       = 32768;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [15:0] sample_t;
  typedef struct packed {
    sample_t right;
    sample_t left;
  } frame_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // left_in, right_in
  logic [31:0]          s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // left_out, right_out
  logic [31:0]          m_axis_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data = '0;

  // predictor copy of the lanes and registers
  sample_t     lane_mem [2][DEPTH];
  int unsigned lane_pos [2];
  len_t        lane_len [2];
  gain_t       fb_gain;
  gain_t       wet_mix;

  frame_t      expected_frames [$];
  int          errors = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 30;
  int          recv_stall_pct = 30;

  stereo_feedback_delay uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // x + g*old in Q15, round half up, clamp to 16 bits
  function automatic sample_t mix_q15(sample_t x, gain_t g, sample_t old);
    longint acc;
    acc = longint'(x) * 32768 + longint'({48'd0, g}) * longint'(old) + 16384;
    acc = acc >>> 15;
    if (acc > 32767)
      acc = 32767;
    else if (acc < -32768)
      acc = -32768;
    return sample_t'(acc);
  endfunction

  function automatic int unsigned lane_limit(len_t n);
    if (n == 0)
      return 1;
    if (n > DEPTH)
      return DEPTH;
    return n;
  endfunction

  function automatic sample_t comb_lane(int ch, sample_t x);
    sample_t old;
    old = lane_mem[ch][lane_pos[ch]];
    lane_mem[ch][lane_pos[ch]] = mix_q15(x, fb_gain, old);
    lane_pos[ch] = (lane_pos[ch] + 1 >= lane_limit(lane_len[ch])) ? 0 : lane_pos[ch] + 1;
    return mix_q15(x, wet_mix, old);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic len_t pick_length();
    case ($urandom_range(11))
      0: return '0;
      1: return 16'd1;
      2: return 16'd32768;
      3: return 16'hffff;
      4: return len_t'($urandom_range(32769, 65534));
      default: return len_t'($urandom_range(2, 48));
    endcase
  endfunction

  function automatic gain_t pick_gain();
    case ($urandom_range(6))
      0: return '0;
      1: return 16'hffff;
      2: return 16'h8000;
      default: return gain_t'($urandom);
    endcase
  endfunction

  task automatic send_frame(sample_t l, sample_t r);
    frame_t f;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, l};
    do @(posedge clk); while (!s_axis_tready);
    f.left  = comb_lane(0, l);
    f.right = comb_lane(1, r);
    expected_frames.push_back(f);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    drain_results();
    // let the last RAM write-back settle before touching lengths or gains
    repeat (3) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_LEFT_LENGTH:   lane_len[0] = v;
      REG_RIGHT_LENGTH:  lane_len[1] = v;
      REG_FEEDBACK_GAIN: fb_gain = v;
      REG_WET_GAIN:      wet_mix = v;
      default: ;
    endcase
  endtask

  task automatic test_defaults();
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh0000, -16'sd1);
    send_frame(16'sd1, 16'sh0000);
  endtask

  // one-slot lines with max gains drive both sums into the rails
  task automatic test_saturation();
    write_reg(REG_LEFT_LENGTH, 16'd1);
    write_reg(REG_RIGHT_LENGTH, 16'd1);
    write_reg(REG_FEEDBACK_GAIN, 16'hffff);
    write_reg(REG_WET_GAIN, 16'hffff);
    repeat (3) send_frame(16'sh7fff, 16'sh8000);
    repeat (3) send_frame(16'sh8000, 16'sh7fff);
  endtask

  task automatic test_lengths();
    int i;
    write_reg(REG_LEFT_LENGTH, 16'd0);
    write_reg(REG_RIGHT_LENGTH, 16'hffff);
    write_reg(REG_FEEDBACK_GAIN, 16'h8000);
    write_reg(REG_WET_GAIN, 16'd0);
    for (i = 0; i < 4; i++)
      send_frame(sample_t'(1000 * (i + 1)), sample_t'(-700 * (i + 1)));
    write_reg(REG_LEFT_LENGTH, 16'd8);
    write_reg(REG_RIGHT_LENGTH, 16'd5);
    write_reg(REG_WET_GAIN, 16'h8000);
    for (i = 0; i < 6; i++)
      send_frame(sample_t'(300 * i - 800), sample_t'(12000 - 4000 * i));
    // shrink the left length below its current position: old slot used, then wrap to zero
    write_reg(REG_LEFT_LENGTH, 16'd3);
    write_reg(REG_RIGHT_LENGTH, 16'd2);
    for (i = 0; i < 4; i++)
      send_frame(sample_t'(5000 - 2500 * i), sample_t'(-3000 + 1500 * i));
  endtask

  task automatic test_random(int sender_idle, int receiver_stall);
    int n;
    int seg;
    send_idle_pct  = sender_idle;
    recv_stall_pct = receiver_stall;
    n = 0;
    while (n < 360) begin
      write_reg(REG_LEFT_LENGTH, pick_length());
      write_reg(REG_RIGHT_LENGTH, pick_length());
      write_reg(REG_FEEDBACK_GAIN, pick_gain());
      write_reg(REG_WET_GAIN, pick_gain());
      seg = $urandom_range(15, 60);
      repeat (seg) begin
        if ($urandom_range(99) == 0)
          drain_results();
        send_frame(pick_sample(), pick_sample());
      end
      n += seg;
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    frame_t got;
    frame_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual left %0d right %0d",
                 $time, got.left, got.right);
      end else begin
        want = expected_frames.pop_front();
        if (got.left !== want.left) begin
          errors++;
          $display("%0t: left_out expected %0d actual %0d", $time, want.left, got.left);
        end
        if (got.right !== want.right) begin
          errors++;
          $display("%0t: right_out expected %0d actual %0d", $time, want.right, got.right);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      lane_mem[0][i] = '0;
      lane_mem[1][i] = '0;
    end
    lane_pos[0] = 0;
    lane_pos[1] = 0;
    lane_len[0] = LEFT_LENGTH_RST;
    lane_len[1] = RIGHT_LENGTH_RST;
    fb_gain     = FEEDBACK_GAIN_RST;
    wet_mix     = WET_GAIN_RST;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_defaults();
    test_saturation();
    test_lengths();
    test_random(22, 59);
    test_random(59, 22);
    test_random(0, 0);

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_frames.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sfd_pkg.sv
rtl/sfd_ram.sv
rtl/sfd_lane.sv
rtl/sfd_outq.sv
rtl/stereo_feedback_delay.sv
dv/stereo_feedback_delay_test.sv
